// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, muted while rst is high.
`define SVN_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge of clk, reset cycles included.
`define SVN_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/svn_pkg.sv =====
// ---------------------------------------------------------------------------
// svn_pkg
// Shared widths, function codes, control structs and a helper for the
// vertex normal block.
// ---------------------------------------------------------------------------
package svn_pkg;

  localparam int MAX_VERTICES = 4096;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int CORNER_W     = 16;
  localparam int VC_W         = 13;
  localparam int POS_W        = 24;
  localparam int EDGE_W       = POS_W + 1;
  localparam int PROD_W       = 2 * EDGE_W;
  localparam int FACE_W       = PROD_W + 1;
  localparam int ACC_W        = 64;
  localparam int NORM_W       = 16;
  localparam int FUNC_W       = 2;

  localparam logic [VC_W-1:0] VC_RESET = VC_W'(MAX_VERTICES);
  localparam logic signed [NORM_W-1:0] NORM_ONE = 16'sd16384;

  localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_TRI  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ = 2'd2;

  typedef logic signed [ACC_W-1:0] acc_t;

  typedef struct packed {
    logic start;
    logic take;
  } nrm_ctrl_t;

  typedef struct packed {
    logic done;
    logic fallback;
  } nrm_stat_t;

  // Saturating add of a face normal component into a 64-bit accumulator.
  function automatic acc_t sat_add(input acc_t a, input logic signed [FACE_W-1:0] b);
    acc_t bx;
    acc_t s;
    bx = ACC_W'(b);
    s  = a + bx;
    if ((a[ACC_W-1] == bx[ACC_W-1]) && (s[ACC_W-1] != a[ACC_W-1])) begin
      s = a[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    return s;
  endfunction

endpackage

// ===== rtl/svn_ram.sv =====
// ---------------------------------------------------------------------------
// svn_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module svn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/svn_norm.sv =====
// ---------------------------------------------------------------------------
// svn_norm
// Iterative normaliser: scale a 64-bit vector to unit length in Q1.14.
// ---------------------------------------------------------------------------
module svn_norm (
  input  logic                                clk,
  input  logic                                rst,
  input  svn_pkg::nrm_ctrl_t                  ctrl,
  input  svn_pkg::acc_t                       sum_x,
  input  svn_pkg::acc_t                       sum_y,
  input  svn_pkg::acc_t                       sum_z,
  output svn_pkg::nrm_stat_t                  stat,
  output logic signed [svn_pkg::NORM_W-1:0]   res_x,
  output logic signed [svn_pkg::NORM_W-1:0]   res_y,
  output logic signed [svn_pkg::NORM_W-1:0]   res_z
);
  import svn_pkg::*;

  localparam int MAG_W   = 20;
  localparam int L2_W    = 2 * MAG_W + 2;
  localparam int NUM_W   = MAG_W + 25;
  localparam int LEN_W   = 32;
  localparam logic [5:0] SQRT_LAST = 6'd31;
  localparam logic [5:0] DIV_LAST  = 6'(NUM_W - 1);

  typedef enum logic [8:0] {
    N_IDLE   = 9'b000000001,
    N_MAX    = 9'b000000010,
    N_SHIFT  = 9'b000000100,
    N_SQ     = 9'b000001000,
    N_SQRT   = 9'b000010000,
    N_DPREP  = 9'b000100000,
    N_DLOAD  = 9'b001000000,
    N_DIV    = 9'b010000000,
    N_DONE   = 9'b100000000
  } nstate_t;

  nstate_t             state;
  logic [ACC_W-1:0]    mag [3];
  logic                neg [3];
  logic [ACC_W-1:0]    big;
  logic [L2_W-1:0]     l2;
  logic [ACC_W-1:0]    sq_x;
  logic [ACC_W-1:0]    sq_res;
  logic [ACC_W-1:0]    sq_bit;
  logic [5:0]          cnt;
  logic [1:0]          k;
  logic [LEN_W-1:0]    len;
  logic [NUM_W-1:0]    num;
  logic [NUM_W-1:0]    quo;
  logic [LEN_W-1:0]    drem;
  logic signed [NORM_W-1:0] res [3];
  logic                fallback;

  logic [ACC_W-1:0]    big_c;
  logic [2*MAG_W-1:0]  sqr;
  logic [L2_W-1:0]     l2_new;
  logic [ACC_W-1:0]    sq_t;
  logic [LEN_W:0]      rem_sh;
  logic                ge;
  logic [NORM_W-1:0]   q16;

  always_comb begin
    big_c = mag[0];
    if (mag[1] > big_c) big_c = mag[1];
    if (mag[2] > big_c) big_c = mag[2];
    sqr    = mag[k][MAG_W-1:0] * mag[k][MAG_W-1:0];
    l2_new = l2 + L2_W'(sqr);
    sq_t   = sq_res + sq_bit;
    rem_sh = {drem, num[NUM_W-1]};
    ge     = rem_sh >= {1'b0, len};
    q16    = (quo > NUM_W'(NORM_ONE)) ? NORM_ONE : quo[NORM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
    end else begin
      unique case (state)
        N_IDLE: begin
          if (ctrl.start) begin
            mag[0] <= sum_x[ACC_W-1] ? -sum_x : sum_x;
            mag[1] <= sum_y[ACC_W-1] ? -sum_y : sum_y;
            mag[2] <= sum_z[ACC_W-1] ? -sum_z : sum_z;
            neg[0] <= sum_x[ACC_W-1];
            neg[1] <= sum_y[ACC_W-1];
            neg[2] <= sum_z[ACC_W-1];
            state  <= N_MAX;
          end
        end
        N_MAX: begin
          big <= big_c;
          if (big_c == '0) begin
            fallback <= 1'b1;
            res[0]   <= '0;
            res[1]   <= NORM_ONE;
            res[2]   <= '0;
            cnt      <= '0;
            state    <= N_DONE;
          end else begin
            state <= N_SHIFT;
          end
        end
        N_SHIFT: begin
          // drop one bit a cycle until the largest magnitude fits 20 bits
          if (big[ACC_W-1:MAG_W] != '0) begin
            big    <= big >> 1;
            mag[0] <= mag[0] >> 1;
            mag[1] <= mag[1] >> 1;
            mag[2] <= mag[2] >> 1;
          end else begin
            l2    <= '0;
            k     <= 2'd0;
            state <= N_SQ;
          end
        end
        N_SQ: begin
          l2 <= l2_new;
          if (k == 2'd2) begin
            sq_x   <= {2'b00, l2_new, 20'b0};
            sq_res <= '0;
            sq_bit <= {2'b01, {(ACC_W-2){1'b0}}};
            cnt    <= '0;
            state  <= N_SQRT;
          end else begin
            k <= k + 2'd1;
          end
        end
        N_SQRT: begin
          if (sq_x >= sq_t) begin
            sq_x   <= sq_x - sq_t;
            sq_res <= (sq_res >> 1) + sq_bit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
          cnt    <= cnt + 6'd1;
          if (cnt == SQRT_LAST) state <= N_DPREP;
        end
        N_DPREP: begin
          len   <= sq_res[LEN_W-1:0];
          k     <= 2'd0;
          state <= N_DLOAD;
        end
        N_DLOAD: begin
          num   <= NUM_W'({mag[k][MAG_W-1:0], 24'b0}) + NUM_W'(len[LEN_W-1:1]);
          quo   <= '0;
          drem  <= '0;
          cnt   <= '0;
          state <= N_DIV;
        end
        N_DIV: begin
          drem <= ge ? LEN_W'(rem_sh - {1'b0, len}) : rem_sh[LEN_W-1:0];
          quo  <= {quo[NUM_W-2:0], ge};
          num  <= num << 1;
          cnt  <= cnt + 6'd1;
          if (cnt == DIV_LAST) begin
            state <= N_DONE;
          end
        end
        N_DONE: begin
          if (quo != '1 && k != 2'd3 && cnt == DIV_LAST + 6'd1) begin
            // store the finished quotient, then move to the next component unless it was the last
            res[k] <= neg[k] ? -$signed(q16) : $signed(q16);
            cnt    <= '0;
            if (k == 2'd2) begin
              fallback <= 1'b0;
            end else begin
              k     <= k + 2'd1;
              state <= N_DLOAD;
            end
          end else if (ctrl.take) begin
            state <= N_IDLE;
          end
        end
        default: state <= N_IDLE;
      endcase
    end
  end

  assign stat.done     = (state == N_DONE) && (cnt != DIV_LAST + 6'd1);
  assign stat.fallback = fallback;
  assign res_x = res[0];
  assign res_y = res[1];
  assign res_z = res[2];

endmodule

// ===== rtl/smooth_vertex_normals.sv =====
// ---------------------------------------------------------------------------
// smooth_vertex_normals
// Area-weighted vertex normals over position and accumulator memories.
// ---------------------------------------------------------------------------
// One item is worked on at a time; in_ready is high only between items.
// A load writes the position and cleared accumulators at the transfer.
// A triangle runs through the transfer, 4 position-read steps on the
// single read port, 7 cross-product steps around the one shared
// multiplier and 6 steps for the three accumulator read-modify-writes.
// A skipped triangle or unused code is finished at the transfer. A read
// shifts the magnitudes right one bit at a time, 0 to 44 times, until
// the largest accumulated magnitude is below 2^20; the square root and
// the three divisions are bit-serial, each division being a load, 45
// quotient steps and a store. A read of a zero accumulated vector takes
// the fallback without the square root or the divisions. A stalled
// output adds its stall to the read. A finished result sits in the
// output register while the next item is accepted. Memory contents are
// undefined until loaded, so there is no clearing pass after reset.
// ---------------------------------------------------------------------------
module smooth_vertex_normals (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [svn_pkg::FUNC_W-1:0]         func,
  input  logic [svn_pkg::IDX_W-1:0]          vertex_index,
  input  logic signed [svn_pkg::POS_W-1:0]   pos_x,
  input  logic signed [svn_pkg::POS_W-1:0]   pos_y,
  input  logic signed [svn_pkg::POS_W-1:0]   pos_z,
  input  logic [svn_pkg::CORNER_W-1:0]       corner_a,
  input  logic [svn_pkg::CORNER_W-1:0]       corner_b,
  input  logic [svn_pkg::CORNER_W-1:0]       corner_c,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [svn_pkg::NORM_W-1:0]  norm_x,
  output logic signed [svn_pkg::NORM_W-1:0]  norm_y,
  output logic signed [svn_pkg::NORM_W-1:0]  norm_z,
  output logic                               fallback_used,
  input  logic                               cfg_we,
  input  logic [svn_pkg::VC_W-1:0]           cfg_wdata
);
  import svn_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_TRI_RD = 7'b0000010,
    S_CROSS  = 7'b0000100,
    S_ACC_RD = 7'b0001000,
    S_ACC_WR = 7'b0010000,
    S_NRM_LD = 7'b0100000,
    S_NRM    = 7'b1000000
  } state_t;

  state_t state;
  logic [VC_W-1:0] vertex_count;
  logic [2:0]      step;
  logic [1:0]      k;
  logic [IDX_W-1:0] crn [3];
  logic signed [POS_W-1:0] vx [3];
  logic signed [POS_W-1:0] vy [3];
  logic signed [POS_W-1:0] vz [3];
  logic signed [EDGE_W-1:0] e0x, e0y, e0z, e1x, e1y, e1z;
  logic signed [PROD_W-1:0] p_hold;
  logic signed [FACE_W-1:0] fx, fy, fz;

  // memory ports
  logic                   pos_we;
  logic [IDX_W-1:0]       pos_raddr;
  logic [3*POS_W-1:0]     pos_rdata;
  logic                   acc_we;
  logic [IDX_W-1:0]       acc_waddr;
  logic [IDX_W-1:0]       acc_raddr;
  logic [3*ACC_W-1:0]     acc_wdata;
  logic [3*ACC_W-1:0]     acc_rdata;

  logic                   in_xfer;
  logic                   tri_ok;
  logic [1:0]             rd_sel;
  logic signed [EDGE_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [FACE_W-1:0] diff;
  acc_t                   ax, ay, az;
  logic                   out_free;
  nrm_ctrl_t              nctrl;
  nrm_stat_t              nstat;
  logic signed [NORM_W-1:0] nx, ny, nz;

  assign in_ready = (state == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // a corner outside the vertex count or the memory skips the triangle
  assign tri_ok = (corner_a < CORNER_W'(vertex_count)) &&
                  (corner_b < CORNER_W'(vertex_count)) &&
                  (corner_c < CORNER_W'(vertex_count)) &&
                  (corner_a < CORNER_W'(MAX_VERTICES)) &&
                  (corner_b < CORNER_W'(MAX_VERTICES)) &&
                  (corner_c < CORNER_W'(MAX_VERTICES));

  // position reads walk corners a, b, c; the fourth step only collects data
  assign rd_sel    = (step[1:0] == 2'd3) ? 2'd0 : step[1:0];
  assign pos_raddr = crn[rd_sel];
  assign pos_we    = in_xfer && (func == FUNC_LOAD);

  assign acc_raddr = (state == S_ACC_RD) ? crn[k] : vertex_index;
  assign acc_waddr = (state == S_ACC_WR) ? crn[k] : vertex_index;
  assign acc_we    = pos_we || (state == S_ACC_WR);

  assign ax = acc_rdata[3*ACC_W-1:2*ACC_W];
  assign ay = acc_rdata[2*ACC_W-1:ACC_W];
  assign az = acc_rdata[ACC_W-1:0];
  assign acc_wdata = (state == S_ACC_WR) ?
                     {sat_add(ax, fx), sat_add(ay, fy), sat_add(az, fz)} : '0;

  // one multiplier, operands chosen by the cross-product step
  always_comb begin
    unique case (step)
      3'd1:    begin mul_a = e0y; mul_b = e1z; end
      3'd2:    begin mul_a = e0z; mul_b = e1y; end
      3'd3:    begin mul_a = e0z; mul_b = e1x; end
      3'd4:    begin mul_a = e0x; mul_b = e1z; end
      3'd5:    begin mul_a = e0x; mul_b = e1y; end
      3'd6:    begin mul_a = e0y; mul_b = e1x; end
      default: begin mul_a = '0;  mul_b = '0;  end
    endcase
    prod = mul_a * mul_b;
    diff = FACE_W'(p_hold) - FACE_W'(prod);
  end

  svn_ram #(.WIDTH(3*POS_W), .DEPTH(MAX_VERTICES)) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (vertex_index),
    .wdata ({pos_x, pos_y, pos_z}),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  svn_ram #(.WIDTH(3*ACC_W), .DEPTH(MAX_VERTICES)) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (acc_wdata),
    .raddr (acc_raddr),
    .rdata (acc_rdata)
  );

  assign nctrl.start = (state == S_NRM_LD);
  assign nctrl.take  = (state == S_NRM) && nstat.done && out_free;

  svn_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (nctrl),
    .sum_x (ax),
    .sum_y (ay),
    .sum_z (az),
    .stat  (nstat),
    .res_x (nx),
    .res_y (ny),
    .res_z (nz)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VC_RESET;
    end else if (cfg_we) begin
      vertex_count <= cfg_wdata;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
      k     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            priority case (func)
              FUNC_TRI: begin
                if (tri_ok) begin
                  crn[0] <= corner_a[IDX_W-1:0];
                  crn[1] <= corner_b[IDX_W-1:0];
                  crn[2] <= corner_c[IDX_W-1:0];
                  step   <= '0;
                  state  <= S_TRI_RD;
                end
              end
              FUNC_READ: state <= S_NRM_LD;
              default: ;
            endcase
          end
        end
        S_TRI_RD: begin
          // collect the corner read in the step before
          if (step != 3'd0) begin
            vx[step[1:0] - 2'd1] <= pos_rdata[3*POS_W-1:2*POS_W];
            vy[step[1:0] - 2'd1] <= pos_rdata[2*POS_W-1:POS_W];
            vz[step[1:0] - 2'd1] <= pos_rdata[POS_W-1:0];
          end
          if (step == 3'd3) begin
            step  <= '0;
            state <= S_CROSS;
          end else begin
            step <= step + 3'd1;
          end
        end
        S_CROSS: begin
          unique case (step)
            3'd0: begin
              e0x <= EDGE_W'(vx[1]) - EDGE_W'(vx[0]);
              e0y <= EDGE_W'(vy[1]) - EDGE_W'(vy[0]);
              e0z <= EDGE_W'(vz[1]) - EDGE_W'(vz[0]);
              e1x <= EDGE_W'(vx[2]) - EDGE_W'(vx[0]);
              e1y <= EDGE_W'(vy[2]) - EDGE_W'(vy[0]);
              e1z <= EDGE_W'(vz[2]) - EDGE_W'(vz[0]);
            end
            3'd1, 3'd3, 3'd5: p_hold <= prod;
            3'd2: fx <= diff;
            3'd4: fy <= diff;
            3'd6: fz <= diff;
            default: ;
          endcase
          if (step == 3'd6) begin
            step  <= '0;
            k     <= 2'd0;
            state <= S_ACC_RD;
          end else begin
            step <= step + 3'd1;
          end
        end
        S_ACC_RD: state <= S_ACC_WR;
        S_ACC_WR: begin
          // the write lands before the next corner is read, so repeated
          // corners see their own update
          if (k == 2'd2) begin
            state <= S_IDLE;
          end else begin
            k     <= k + 2'd1;
            state <= S_ACC_RD;
          end
        end
        S_NRM_LD: state <= S_NRM;
        S_NRM: begin
          if (nctrl.take) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register: hold until transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (nctrl.take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (nctrl.take) begin
      norm_x        <= nx;
      norm_y        <= ny;
      norm_z        <= nz;
      fallback_used <= nstat.fallback;
    end
  end

endmodule

// ===== rtl/svn_checker.sv =====
// ---------------------------------------------------------------------------
// svn_checker
// Port-level checks on the vertex normal block, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module svn_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic [svn_pkg::FUNC_W-1:0]         func,
  input logic [svn_pkg::IDX_W-1:0]          vertex_index,
  input logic signed [svn_pkg::POS_W-1:0]   pos_x,
  input logic signed [svn_pkg::POS_W-1:0]   pos_y,
  input logic signed [svn_pkg::POS_W-1:0]   pos_z,
  input logic [svn_pkg::CORNER_W-1:0]       corner_a,
  input logic [svn_pkg::CORNER_W-1:0]       corner_b,
  input logic [svn_pkg::CORNER_W-1:0]       corner_c,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [svn_pkg::NORM_W-1:0]  norm_x,
  input logic signed [svn_pkg::NORM_W-1:0]  norm_y,
  input logic signed [svn_pkg::NORM_W-1:0]  norm_z,
  input logic                               fallback_used,
  input logic                               cfg_we,
  input logic [svn_pkg::VC_W-1:0]           cfg_wdata
);
  import svn_pkg::*;

  `SVN_ASSERT_ALWAYS(a_reset_clears_out, rst |=> !out_valid, "result valid after reset")

  `SVN_ASSERT(a_out_holds, out_valid && !out_ready |=> out_valid && $stable(norm_x), "stalled result dropped")

  `SVN_ASSERT(a_fallback_vec, out_valid && fallback_used |-> norm_x == 16'sd0 && norm_y == NORM_ONE && norm_z == 16'sd0, "bad fallback vector")

  `SVN_ASSERT(a_unit_range, out_valid && !fallback_used |-> norm_y <= NORM_ONE && norm_y >= -NORM_ONE, "component out of range")

  `SVN_ASSERT(a_load_one_cycle, in_valid && in_ready && func == FUNC_LOAD |=> in_ready, "load held the block busy")

endmodule

bind smooth_vertex_normals svn_checker u_svn_checker (.*);

// ===== tb/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for smooth_vertex_normals: loads vertices, adds
// triangles and reads normals through the valid/ready ports, predicts each
// normal from a bit-exact local copy of the memories and compares results.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import svn_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;   // unused code, ignored
  localparam int CYCLE_LIMIT = 3000000;
  localparam longint ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint ACC_MIN = 64'sh8000_0000_0000_0000;

  typedef struct {
    logic [FUNC_W-1:0]       fn;
    logic [IDX_W-1:0]        idx;
    logic signed [POS_W-1:0] px, py, pz;
    logic [CORNER_W-1:0]     ca, cb, cc;
  } vtx_item_t;

  typedef struct {
    logic signed [NORM_W-1:0] nx, ny, nz;
    logic                     fb;
  } normal_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [FUNC_W-1:0] func = '0;
  logic [IDX_W-1:0] vertex_index = '0;
  logic signed [POS_W-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic [CORNER_W-1:0] corner_a = '0, corner_b = '0, corner_c = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [NORM_W-1:0] norm_x, norm_y, norm_z;
  logic fallback_used;
  logic cfg_we = 1'b0;
  logic [VC_W-1:0] cfg_wdata = '0;

  smooth_vertex_normals u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .vertex_index(vertex_index),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .corner_a(corner_a), .corner_b(corner_b), .corner_c(corner_c),
    .out_valid(out_valid), .out_ready(out_ready),
    .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
    .fallback_used(fallback_used),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Local copy of the block's state, advanced at each accepted transfer
  int     pos_mem_x[MAX_VERTICES], pos_mem_y[MAX_VERTICES], pos_mem_z[MAX_VERTICES];
  longint sum_mem_x[MAX_VERTICES], sum_mem_y[MAX_VERTICES], sum_mem_z[MAX_VERTICES];
  int     vcount_now = MAX_VERTICES;

  // Generation-side view of which slots hold a position
  bit     slot_loaded[MAX_VERTICES];
  int     loaded_slots[$];

  vtx_item_t pending_items[$];
  normal_t   expected_normals[$];
  vtx_item_t cur_item;
  bit        quiet = 1'b0;
  int        err_count = 0;
  int        gap_in = 0, gap_out = 0;
  longint    cycles = 0;

  task automatic report(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    err_count++;
  endtask

  function automatic longint sat_sum(input longint a, input longint b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(ACC_MAX)) return ACC_MAX;
    if (s < 65'(ACC_MIN)) return ACC_MIN;
    return longint'(s);
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Scale the accumulated vector of one slot to unit length in Q1.14
  function automatic normal_t unit_normal(input int v);
    longint c[3];
    longint unsigned m[3], big, l2, len, q;
    int s;
    normal_t r;
    c[0] = sum_mem_x[v];
    c[1] = sum_mem_y[v];
    c[2] = sum_mem_z[v];
    for (int i = 0; i < 3; i++) m[i] = c[i] < 0 ? 64'd0 - c[i] : c[i];
    big = m[0];
    if (m[1] > big) big = m[1];
    if (m[2] > big) big = m[2];
    if (big == 0) begin
      r.nx = '0; r.ny = NORM_ONE; r.nz = '0; r.fb = 1'b1;
      return r;
    end
    s = 0;
    while ((big >> s) >= (64'd1 << 20)) s++;
    l2 = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] >>= s;
      l2 += m[i] * m[i];
    end
    len = int_sqrt(l2 << 20);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << 24) + (len >> 1)) / len;
      if (q > 16384) q = 16384;
      m[i] = c[i] < 0 ? 64'd0 - q : q;
    end
    r.nx = m[0][15:0]; r.ny = m[1][15:0]; r.nz = m[2][15:0]; r.fb = 1'b0;
    return r;
  endfunction

  // Advance the local state for one accepted transfer; queue any result
  task automatic apply_item(input vtx_item_t it);
    longint e0x, e0y, e0z, e1x, e1y, e1z, fx, fy, fz;
    int k[3];
    case (it.fn)
      FUNC_LOAD: begin
        pos_mem_x[it.idx] = int'(it.px);
        pos_mem_y[it.idx] = int'(it.py);
        pos_mem_z[it.idx] = int'(it.pz);
        sum_mem_x[it.idx] = 0; sum_mem_y[it.idx] = 0; sum_mem_z[it.idx] = 0;
      end
      FUNC_TRI: begin
        if (it.ca < vcount_now && it.cb < vcount_now && it.cc < vcount_now &&
            it.ca < MAX_VERTICES && it.cb < MAX_VERTICES && it.cc < MAX_VERTICES) begin
          k[0] = int'(it.ca); k[1] = int'(it.cb); k[2] = int'(it.cc);
          e0x = longint'(pos_mem_x[k[1]]) - pos_mem_x[k[0]];
          e0y = longint'(pos_mem_y[k[1]]) - pos_mem_y[k[0]];
          e0z = longint'(pos_mem_z[k[1]]) - pos_mem_z[k[0]];
          e1x = longint'(pos_mem_x[k[2]]) - pos_mem_x[k[0]];
          e1y = longint'(pos_mem_y[k[2]]) - pos_mem_y[k[0]];
          e1z = longint'(pos_mem_z[k[2]]) - pos_mem_z[k[0]];
          fx = e0y * e1z - e0z * e1y;
          fy = e0z * e1x - e0x * e1z;
          fz = e0x * e1y - e0y * e1x;
          for (int i = 0; i < 3; i++) begin
            sum_mem_x[k[i]] = sat_sum(sum_mem_x[k[i]], fx);
            sum_mem_y[k[i]] = sat_sum(sum_mem_y[k[i]], fy);
            sum_mem_z[k[i]] = sat_sum(sum_mem_z[k[i]], fz);
          end
        end
      end
      FUNC_READ: expected_normals.push_back(unit_normal(int'(it.idx)));
      default: ;
    endcase
  endtask

  // Driver: present pending items, with random idle bursts between them
  always @(posedge clk) begin
    logic nv;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      nv = in_valid;
      if (in_valid && in_ready) begin
        apply_item(cur_item);
        nv = 1'b0;
      end
      if (!nv) begin
        if (gap_in > 0) begin
          gap_in--;
        end else if (pending_items.size() > 0) begin
          if (!quiet && $urandom_range(0, 9) == 0) begin
            gap_in = $urandom_range(1, 18) - 1;
          end else begin
            cur_item = pending_items.pop_front();
            func <= cur_item.fn;
            vertex_index <= cur_item.idx;
            pos_x <= cur_item.px; pos_y <= cur_item.py; pos_z <= cur_item.pz;
            corner_a <= cur_item.ca; corner_b <= cur_item.cb; corner_c <= cur_item.cc;
            nv = 1'b1;
          end
        end
      end
      in_valid <= nv;
    end
  end

  // Monitor: stall the output in random bursts, compare each transfer
  always @(posedge clk) begin
    normal_t e;
    logic r;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_normals.size() == 0) begin
          report("normal transferred with none expected");
        end else begin
          e = expected_normals.pop_front();
          if (norm_x !== e.nx) report($sformatf("norm_x %0d, want %0d", norm_x, e.nx));
          if (norm_y !== e.ny) report($sformatf("norm_y %0d, want %0d", norm_y, e.ny));
          if (norm_z !== e.nz) report($sformatf("norm_z %0d, want %0d", norm_z, e.nz));
          if (fallback_used !== e.fb)
            report($sformatf("fallback_used %0b, want %0b", fallback_used, e.fb));
        end
      end
      if (gap_out > 0) begin
        gap_out--;
        r = 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        gap_out = $urandom_range(1, 18) - 1;
        r = 1'b0;
      end else begin
        r = 1'b1;
      end
      out_ready <= r;
    end
  end

  // Guard against a hung handshake
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Queue one item; track which slots now hold a position
  task automatic queue_item(input vtx_item_t it);
    if (it.fn == FUNC_LOAD && !slot_loaded[it.idx]) begin
      slot_loaded[it.idx] = 1'b1;
      loaded_slots.push_back(int'(it.idx));
    end
    pending_items.push_back(it);
  endtask

  function automatic vtx_item_t noise_item(input logic [FUNC_W-1:0] fn);
    vtx_item_t it;
    it.fn = fn;
    it.idx = IDX_W'($urandom);
    it.px = POS_W'($urandom); it.py = POS_W'($urandom); it.pz = POS_W'($urandom);
    it.ca = CORNER_W'($urandom); it.cb = CORNER_W'($urandom); it.cc = CORNER_W'($urandom);
    return it;
  endfunction

  function automatic logic signed [POS_W-1:0] rand_pos();
    case ($urandom_range(0, 7))
      0: return {1'b0, {(POS_W-1){1'b1}}};
      1: return {1'b1, {(POS_W-1){1'b0}}};
      2: return '0;
      3, 4: return POS_W'($urandom);
      default: return POS_W'($signed($urandom_range(0, 131072)) - 65536);
    endcase
  endfunction

  task automatic queue_load(input int idx);
    vtx_item_t it;
    it = noise_item(FUNC_LOAD);
    it.idx = IDX_W'(idx);
    it.px = rand_pos(); it.py = rand_pos(); it.pz = rand_pos();
    queue_item(it);
  endtask

  task automatic queue_tri(input int a, input int b, input int c);
    vtx_item_t it;
    it = noise_item(FUNC_TRI);
    it.ca = CORNER_W'(a); it.cb = CORNER_W'(b); it.cc = CORNER_W'(c);
    queue_item(it);
  endtask

  task automatic queue_read(input int idx);
    vtx_item_t it;
    it = noise_item(FUNC_READ);
    it.idx = IDX_W'(idx);
    queue_item(it);
  endtask

  // One phase of random traffic, mostly on a small pool of slots
  task automatic queue_random(input int n);
    int in_range[$];
    int pool, sel, bad;
    pool = vcount_now < 24 ? vcount_now : 24;
    for (int i = 0; i < n; i++) begin
      in_range = loaded_slots.find(x) with (x < vcount_now);
      sel = $urandom_range(0, 99);
      if (sel < 22 || loaded_slots.size() == 0 || (sel < 65 && in_range.size() == 0)) begin
        queue_load($urandom_range(0, 4) == 0 ? $urandom_range(0, MAX_VERTICES - 1)
                                             : $urandom_range(0, pool - 1));
      end else if (sel < 60) begin
        queue_tri(in_range[$urandom_range(0, in_range.size() - 1)],
                  in_range[$urandom_range(0, in_range.size() - 1)],
                  in_range[$urandom_range(0, in_range.size() - 1)]);
      end else if (sel < 65) begin
        // at least one corner out of range: the whole triangle is dropped
        bad = $urandom_range(vcount_now, 65535);
        case ($urandom_range(0, 2))
          0: queue_tri(bad, $urandom_range(0, 65535), $urandom_range(0, 65535));
          1: queue_tri($urandom_range(0, 65535), bad, $urandom_range(0, 65535));
          default: queue_tri($urandom_range(0, 65535), $urandom_range(0, 65535), bad);
        endcase
      end else if (sel < 95) begin
        queue_read(loaded_slots[$urandom_range(0, loaded_slots.size() - 1)]);
      end else begin
        queue_item(noise_item(FUNC_NONE));
      end
    end
  endtask

  // Wait until every item is taken, the block is idle and every normal
  // has come back; sample between edges so the driver has settled
  task automatic drain();
    while (pending_items.size() != 0 || in_valid || !in_ready ||
           expected_normals.size() != 0)
      @(negedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_vcount(input int v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= VC_W'(v);
    vcount_now = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: extreme positions, zero-area and skipped triangles, idle code
    write_vcount(MAX_VERTICES);
    queue_load(0);
    pending_items[$].px = {1'b0, {(POS_W-1){1'b1}}};
    pending_items[$].py = {1'b1, {(POS_W-1){1'b0}}};
    pending_items[$].pz = '0;
    queue_load(1);
    pending_items[$].px = {1'b1, {(POS_W-1){1'b0}}};
    pending_items[$].py = {1'b0, {(POS_W-1){1'b1}}};
    pending_items[$].pz = {1'b0, {(POS_W-1){1'b1}}};
    queue_load(2);
    pending_items[$].px = {1'b1, {(POS_W-1){1'b0}}};
    pending_items[$].py = {1'b1, {(POS_W-1){1'b0}}};
    pending_items[$].pz = {1'b1, {(POS_W-1){1'b0}}};
    queue_read(0);                        // zero vector gives the fallback
    queue_tri(0, 1, 2);
    queue_tri(2, 0, 1);
    queue_read(0);
    queue_read(1);
    queue_read(2);
    queue_tri(0, 0, 1);                   // zero area adds nothing
    queue_tri(0, 1, 65535);               // out of range, dropped
    queue_tri(4096, 1, 2);
    queue_item(noise_item(FUNC_NONE));
    queue_load(MAX_VERTICES - 1);
    pending_items[$].px = '1; pending_items[$].py = 24'sd1; pending_items[$].pz = '0;
    queue_tri(MAX_VERTICES - 1, 0, 1);
    queue_read(MAX_VERTICES - 1);
    queue_load(1);                        // reload clears the sum
    queue_read(1);
    queue_read(0);
    drain();

    write_vcount(3);
    queue_random(300);
    drain();
    write_vcount(1);
    queue_random(150);
    drain();
    write_vcount(MAX_VERTICES);
    queue_random(650);
    drain();
    write_vcount($urandom_range(2, MAX_VERTICES));
    queue_random(550);
    drain();
    write_vcount(MAX_VERTICES);
    quiet = 1'b1;                         // last stretch runs without idling
    queue_random(250);
    drain();

    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
